// File: rtl/clns_pkg.sv
package clns_pkg;

  // Depth of the job queue between the request front and the segment back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  typedef enum logic [1:0] {
    FuncCmd  = 2'd0,
    FuncData = 2'd1,
    FuncInit = 2'd2,
    FuncGoto = 2'd3
  } func_e;

  localparam logic [CfgIdxW-1:0] RegEnablePulse = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPowerUp     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCmdSettle   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegClearSettle = 2'd3;

  localparam logic [CfgW-1:0] EnablePulseRst = 16'd1000;
  localparam logic [CfgW-1:0] PowerUpRst     = 16'd35000;
  localparam logic [CfgW-1:0] CmdSettleRst   = 16'd45;
  localparam logic [CfgW-1:0] ClearSettleRst = 16'd2000;

  localparam logic [3:0] LoneNibble     = 4'b0010;
  localparam logic [7:0] CmdFunctionSet = 8'b0010_1000;
  localparam logic [7:0] CmdDisplayCtrl = 8'b0000_1111;
  localparam logic [7:0] CmdClear       = 8'b0000_0001;
  localparam logic [7:0] CmdEntryMode   = 8'b0000_0110;
  localparam logic [7:0] CmdSetAddr     = 8'h80;

  // One unit of work for the back end: a single byte, or the whole init run.
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic [CfgW-1:0] enable_pulse;
    logic [CfgW-1:0] power_up;
    logic [CfgW-1:0] cmd_settle;
    logic [CfgW-1:0] clear_settle;
  } cfg_t;

  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold;
    logic        last;
  } seg_t;

  function automatic logic [7:0] line_offset(input logic [1:0] line);
    logic [7:0] off;
    case (line)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      2'd3:    off = 8'h54;
      default: off = 8'h00;
    endcase
    return off;
  endfunction

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CmdFunctionSet;
      2'd1:    b = CmdDisplayCtrl;
      2'd2:    b = CmdClear;
      2'd3:    b = CmdEntryMode;
      default: b = CmdEntryMode;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/clns_front.sv
module clns_front (
  input  logic              push,
  output logic              full,
  input  logic [1:0]        func_i,
  input  logic [7:0]        value_i,
  input  logic [2:0]        line_i,
  input  logic [6:0]        cell_req_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output clns_pkg::job_t    q_job_o
);
  import clns_pkg::*;

  logic       accept;
  logic [7:0] goto_cmd;
  logic       drop;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;

  // Set-address command wraps modulo 256 by the 8-bit sum.
  assign goto_cmd = CmdSetAddr + line_offset(line_i[1:0]) + {1'b0, cell_req_i};

  // A goto to a line beyond the fourth produces nothing at all.
  assign drop = (func_i == FuncGoto) && line_i[2];

  always_comb begin
    q_job_o = '{is_init: 1'b0, rs: 1'b0, data: value_i};
    case (func_i)
      FuncCmd:  q_job_o.rs = 1'b0;
      FuncData: q_job_o.rs = 1'b1;
      FuncInit: q_job_o.is_init = 1'b1;
      FuncGoto: q_job_o.data = goto_cmd;
      default:  q_job_o.rs = 1'b0;
    endcase
  end

  assign q_push_o = accept && !drop;

endmodule

// File: rtl/clns_queue.sv
module clns_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clns_pkg::job_t wdata_i,
  output logic           full_o,
  output logic           avail_o,
  input  logic           pop_i,
  output clns_pkg::job_t rdata_o
);
  import clns_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign avail_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("job queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("job queue popped while empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != QCntW'(QDepth))
    else $error("job queue pushed while full");

endmodule

// File: rtl/clns_back.sv
module clns_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clns_pkg::cfg_t cfg_i,
  input  logic           job_avail_i,
  input  clns_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           seg_vld_o,
  output clns_pkg::seg_t seg_o,
  input  logic           seg_pop_i
);
  import clns_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StPower = 2'd1;
  localparam logic [1:0] StLone  = 2'd2;
  localparam logic [1:0] StBytes = 2'd3;

  localparam logic [2:0] PhHiPulse = 3'd1;
  localparam logic [2:0] PhLoneEnd = 3'd2;
  localparam logic [2:0] PhLoStart = 3'd3;
  localparam logic [2:0] PhLoPulse = 3'd4;
  localparam logic [2:0] PhByteEnd = 3'd5;
  localparam logic [1:0] LastByte  = 2'd3;

  logic [1:0] st_q, st_d;
  logic [2:0] ph_q, ph_d;
  logic [1:0] bi_q, bi_d;
  job_t       job_q, job_d;
  logic       vld_q, vld_d;
  seg_t       seg_q, seg_d;

  logic       adv;
  logic [7:0] cur_byte;
  logic [15:0] settle;
  seg_t       seg_cur;

  assign adv = !vld_q || seg_pop_i;

  assign cur_byte = job_q.is_init ? init_byte(bi_q) : job_q.data;

  always_comb begin
    settle = '0;
    if (job_q.is_init) begin
      case (bi_q)
        2'd0, 2'd1: settle = cfg_i.cmd_settle;
        2'd2:       settle = cfg_i.clear_settle;
        default:    settle = '0;
      endcase
    end
  end

  always_comb begin
    seg_cur = '{rs: job_q.rs, en: 1'b0, nib: 4'd0, hold: 16'd0, last: 1'b0};
    case (st_q)
      StPower: begin
        seg_cur.rs   = 1'b0;
        seg_cur.hold = cfg_i.power_up;
      end
      StLone: begin
        seg_cur.rs   = 1'b0;
        seg_cur.nib  = LoneNibble;
        seg_cur.en   = (ph_q == PhHiPulse);
        seg_cur.hold = seg_cur.en ? cfg_i.enable_pulse : 16'd0;
      end
      StBytes: begin
        seg_cur.nib  = (ph_q < PhLoStart) ? cur_byte[7:4] : cur_byte[3:0];
        seg_cur.en   = (ph_q == PhHiPulse) || (ph_q == PhLoPulse);
        seg_cur.hold = seg_cur.en ? cfg_i.enable_pulse
                     : ((ph_q == PhByteEnd) ? settle : 16'd0);
        seg_cur.last = (ph_q == PhByteEnd) && (!job_q.is_init || bi_q == LastByte);
      end
      default: seg_cur.rs = job_q.rs;
    endcase
  end

  always_comb begin
    st_d      = st_q;
    ph_d      = ph_q;
    bi_d      = bi_q;
    job_d     = job_q;
    vld_d     = vld_q;
    seg_d     = seg_q;
    job_pop_o = 1'b0;

    if (adv) begin
      vld_d = 1'b0;
    end

    case (st_q)
      StIdle: begin
        if (job_avail_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          ph_d      = '0;
          bi_d      = '0;
          st_d      = job_i.is_init ? StPower : StBytes;
        end
      end
      StPower: begin
        if (adv) begin
          st_d = StLone;
          ph_d = '0;
        end
      end
      StLone: begin
        if (adv) begin
          if (ph_q == PhLoneEnd) begin
            st_d = StBytes;
            ph_d = '0;
          end else begin
            ph_d = ph_q + 1'b1;
          end
        end
      end
      StBytes: begin
        if (adv) begin
          if (ph_q == PhByteEnd) begin
            ph_d = '0;
            if (seg_cur.last) begin
              st_d = StIdle;
            end else begin
              bi_d = bi_q + 1'b1;
            end
          end else begin
            ph_d = ph_q + 1'b1;
          end
        end
      end
      default: st_d = StIdle;
    endcase

    if (adv && st_q != StIdle) begin
      vld_d = 1'b1;
      seg_d = seg_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      ph_q  <= '0;
      bi_q  <= '0;
      vld_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      ph_q  <= ph_d;
      bi_q  <= bi_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    seg_q <= seg_d;
  end

  assign seg_vld_o = vld_q;
  assign seg_o     = seg_q;

  a_last_enable_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && seg_q.last |-> !seg_q.en)
    else $error("final segment shown with enable high");

  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> (st_q == StIdle) && job_avail_i)
    else $error("job taken outside idle or from an empty queue");

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StBytes) |-> (ph_q <= PhByteEnd))
    else $error("byte phase out of range");

  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle) |-> (ph_q == '0))
    else $error("phase counter not cleared at end of job");

endmodule

// File: rtl/char_lcd_nibble_sequencer.sv
// Character LCD sequencer for the 4-bit bus mode.
// Requests come in through a queue-style port: a transfer happens at a rising
// edge with push high and full low. func selects a command byte, a data byte,
// the init run, or a goto that is turned into a set-address command.
// Results leave through a second queue-style port: while empty is low the
// oldest pin segment (reg_select, enable, nibble, hold_us, last) is on the
// outputs, and a transfer happens at a rising edge with pop high.
// A byte gives six segments, init gives 28, and a goto to lines four to seven
// gives none. last marks the final segment of each request.
// The first segment of a request passes from the job queue through the job
// register of the segment sequencer into the result register. With pop held
// high the segment sequencer gives one segment per cycle, and between jobs it
// returns to idle to fetch the next job from the two-entry job queue.
// When the receiver stalls, the current segment holds and the sequencer
// waits; requests keep being taken until the job queue fills, then full rises.
// Reset empties the job queue and the result register and loads the four
// timing registers with their defaults. The user must write them through
// cfg_we_i, cfg_index_i, cfg_data_i only while the block is idle; not enforced.
module char_lcd_nibble_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    func_i,
  input  logic [7:0]                    value_i,
  input  logic [2:0]                    line_i,
  input  logic [6:0]                    cell_req_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          reg_select_o,
  output logic                          enable_o,
  output logic [3:0]                    nibble_o,
  output logic [15:0]                   hold_us_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [clns_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [clns_pkg::CfgW-1:0]     cfg_data_i
);
  import clns_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  q_full, q_push, q_avail, q_pop;
  job_t  q_wjob, q_rjob;
  logic  seg_vld;
  seg_t  seg;

  // Timing registers. A write to an index outside the list changes nothing.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegEnablePulse: cfg_d.enable_pulse = cfg_data_i;
        RegPowerUp:     cfg_d.power_up     = cfg_data_i;
        RegCmdSettle:   cfg_d.cmd_settle   = cfg_data_i;
        RegClearSettle: cfg_d.clear_settle = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable_pulse: EnablePulseRst, power_up: PowerUpRst,
                 cmd_settle: CmdSettleRst, clear_settle: ClearSettleRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front classifies each request into a job and drops dead gotos.
  clns_front u_front (
    .push       (push),
    .full       (full),
    .func_i     (func_i),
    .value_i    (value_i),
    .line_i     (line_i),
    .cell_req_i (cell_req_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_wjob)
  );

  // The job queue lets the front keep taking requests while the back is busy.
  clns_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wjob),
    .full_o  (q_full),
    .avail_o (q_avail),
    .pop_i   (q_pop),
    .rdata_o (q_rjob)
  );

  // The back steps through the segments of one job into the result register.
  clns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_avail_i (q_avail),
    .job_i       (q_rjob),
    .job_pop_o   (q_pop),
    .seg_vld_o   (seg_vld),
    .seg_o       (seg),
    .seg_pop_i   (pop)
  );

  assign empty        = !seg_vld;
  assign reg_select_o = seg.rs;
  assign enable_o     = seg.en;
  assign nibble_o     = seg.nib;
  assign hold_us_o    = seg.hold;
  assign last_o       = seg.last;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the 4-bit character LCD segment sequencer.
// Requests enter through a queue-style push/full port and pin segments leave
// through a queue-style empty/pop port. Every accepted request is expanded by
// a local model into the segments it must produce. Every segment that the
// block hands over is compared field by field with the oldest segment still
// owed.
module tb_top;
  import clns_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned NumPhases   = 5;

  // One request as it is sent. Rows marked typed carry the expected bus byte
  // directly, or the note that the request must produce no segment at all;
  // every other request is expanded by the model below.
  typedef struct packed {
    func_e      fn;
    logic [7:0] value;
    logic [2:0] line;
    logic [6:0] column;
    logic       typed;
    logic       silent;
    logic       rs;
    logic [7:0] bus_byte;
  } lcd_req_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                push        = 1'b0;
  logic                full;
  logic [1:0]          func_i      = '0;
  logic [7:0]          value_i     = '0;
  logic [2:0]          line_i      = '0;
  logic [6:0]          cell_req_i  = '0;
  logic                empty;
  logic                pop         = 1'b0;
  logic                reg_select_o;
  logic                enable_o;
  logic [3:0]          nibble_o;
  logic [15:0]         hold_us_o;
  logic                last_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgW-1:0]     cfg_data_i  = '0;

  // Local copy of the timing registers, kept in step with every write.
  logic [15:0] pulse_us    = EnablePulseRst;
  logic [15:0] powerup_us  = PowerUpRst;
  logic [15:0] cmd_wait_us = CmdSettleRst;
  logic [15:0] clr_wait_us = ClearSettleRst;

  // Segments owed by the block, oldest first.
  seg_t        owed_segs[$];
  int unsigned err_count   = 0;
  int unsigned seg_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          src_idle    = 1'b1;
  bit          snk_idle    = 1'b1;

  char_lcd_nibble_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .value_i     (value_i),
    .line_i      (line_i),
    .cell_req_i  (cell_req_i),
    .empty       (empty),
    .pop         (pop),
    .reg_select_o(reg_select_o),
    .enable_o    (enable_o),
    .nibble_o    (nibble_o),
    .hold_us_o   (hold_us_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // The directed rows: both ends of every field, all four request kinds, all
  // eight lines (the upper four must stay silent), goto addresses that wrap
  // past 0xFF, and init with garbage in the fields it ignores. They run with
  // the timing registers at their reset values, so the typed rows also show
  // the default enable pulse.
  lcd_req_t directed_rows [0:21] = '{
    '{FuncCmd,  8'h00, 3'd0, 7'd0,   1'b1, 1'b0, 1'b0, 8'h00},
    '{FuncCmd,  8'hFF, 3'd0, 7'd0,   1'b1, 1'b0, 1'b0, 8'hFF},
    '{FuncData, 8'h00, 3'd0, 7'd0,   1'b1, 1'b0, 1'b1, 8'h00},
    '{FuncData, 8'hFF, 3'd0, 7'd0,   1'b1, 1'b0, 1'b1, 8'hFF},
    '{FuncData, 8'hA5, 3'd0, 7'd0,   1'b1, 1'b0, 1'b1, 8'hA5},
    '{FuncInit, 8'hFF, 3'd0, 7'd0,   1'b0, 1'b0, 1'b0, 8'h00},
    '{FuncGoto, 8'h00, 3'd0, 7'd0,   1'b1, 1'b0, 1'b0, 8'h80},
    '{FuncGoto, 8'h00, 3'd1, 7'd0,   1'b1, 1'b0, 1'b0, 8'hC0},
    '{FuncGoto, 8'h00, 3'd2, 7'd0,   1'b1, 1'b0, 1'b0, 8'h94},
    '{FuncGoto, 8'h00, 3'd3, 7'd0,   1'b1, 1'b0, 1'b0, 8'hD4},
    '{FuncGoto, 8'hFF, 3'd3, 7'd127, 1'b1, 1'b0, 1'b0, 8'h53},
    '{FuncGoto, 8'h00, 3'd1, 7'd127, 1'b1, 1'b0, 1'b0, 8'h3F},
    '{FuncGoto, 8'h33, 3'd4, 7'd5,   1'b1, 1'b1, 1'b0, 8'h00},
    '{FuncGoto, 8'hFF, 3'd7, 7'd127, 1'b1, 1'b1, 1'b0, 8'h00},
    '{FuncGoto, 8'h00, 3'd5, 7'd64,  1'b1, 1'b1, 1'b0, 8'h00},
    '{FuncGoto, 8'h81, 3'd6, 7'd1,   1'b1, 1'b1, 1'b0, 8'h00},
    '{FuncCmd,  8'h5A, 3'd7, 7'd127, 1'b1, 1'b0, 1'b0, 8'h5A},
    '{FuncData, 8'h3C, 3'd3, 7'd64,  1'b0, 1'b0, 1'b0, 8'h00},
    '{FuncInit, 8'h00, 3'd7, 7'd127, 1'b0, 1'b0, 1'b0, 8'h00},
    '{FuncGoto, 8'hAA, 3'd0, 7'd127, 1'b1, 1'b0, 1'b0, 8'hFF},
    '{FuncGoto, 8'h00, 3'd2, 7'd108, 1'b1, 1'b0, 1'b0, 8'h00},
    '{FuncData, 8'h5A, 3'd4, 7'd0,   1'b0, 1'b0, 1'b0, 8'h00}
  };

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // ---------------------------------------------------------------------
  // Segment model. A nibble goes out as enable low, enable high for the
  // pulse time, enable low. A byte is its high nibble then its low nibble,
  // with the settle time on its final segment.
  // ---------------------------------------------------------------------
  task automatic owe_seg(input logic rs, input logic en, input logic [3:0] nib,
                         input logic [15:0] hold, input logic fin);
    owed_segs.push_back('{rs: rs, en: en, nib: nib, hold: hold, last: fin});
  endtask

  task automatic owe_nibble(input logic rs, input logic [3:0] nib);
    owe_seg(rs, 1'b0, nib, 16'd0, 1'b0);
    owe_seg(rs, 1'b1, nib, pulse_us, 1'b0);
    owe_seg(rs, 1'b0, nib, 16'd0, 1'b0);
  endtask

  task automatic owe_byte(input logic rs, input logic [7:0] b,
                          input logic [15:0] settle, input logic fin);
    owe_nibble(rs, b[7:4]);
    owe_seg(rs, 1'b0, b[3:0], 16'd0, 1'b0);
    owe_seg(rs, 1'b1, b[3:0], pulse_us, 1'b0);
    owe_seg(rs, 1'b0, b[3:0], settle, fin);
  endtask

  task automatic owe_request(input func_e fn, input logic [7:0] value,
                             input logic [2:0] line, input logic [6:0] column);
    logic [7:0] row_base;
    case (fn)
      FuncCmd:  owe_byte(1'b0, value, 16'd0, 1'b1);
      FuncData: owe_byte(1'b1, value, 16'd0, 1'b1);
      FuncInit: begin
        // Power-up wait, the lone nibble that selects 4-bit mode, then the
        // four setup commands; the entry mode command ends with no wait.
        owe_seg(1'b0, 1'b0, 4'h0, powerup_us, 1'b0);
        owe_nibble(1'b0, LoneNibble);
        owe_byte(1'b0, CmdFunctionSet, cmd_wait_us, 1'b0);
        owe_byte(1'b0, CmdDisplayCtrl, cmd_wait_us, 1'b0);
        owe_byte(1'b0, CmdClear, clr_wait_us, 1'b0);
        owe_byte(1'b0, CmdEntryMode, 16'd0, 1'b1);
      end
      default: begin
        // Lines four to seven do not exist and produce nothing.
        if (line < 3'd4) begin
          case (line[1:0])
            2'd0:    row_base = 8'h00;
            2'd1:    row_base = 8'h40;
            2'd2:    row_base = 8'h14;
            default: row_base = 8'h54;
          endcase
          owe_byte(1'b0, CmdSetAddr + row_base + {1'b0, column}, 16'd0, 1'b1);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Request side. The gap before each request is drawn per item; push stays
  // high across back-to-back requests so it is never dropped and raised in
  // the same step.
  // ---------------------------------------------------------------------
  task automatic send_request(input lcd_req_t r);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    func_i     <= r.fn;
    value_i    <= r.value;
    line_i     <= r.line;
    cell_req_i <= r.column;
    do @(posedge clk_i); while (full);
    // The transfer happened at this edge; its segments are owed from now on.
    if (r.typed) begin
      if (!r.silent) owe_byte(r.rs, r.bus_byte, 16'd0, 1'b1);
    end else begin
      owe_request(r.fn, r.value, r.line, r.column);
    end
  endtask

  // Drop push and wait until every owed segment has been taken, then give the
  // block time to return to idle before the next write.
  task automatic drain_block();
    push <= 1'b0;
    while (owed_segs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // All four timing registers, written on consecutive edges.
  task automatic set_timing(input logic [15:0] pulse, input logic [15:0] pwr,
                            input logic [15:0] cmd, input logic [15:0] clr);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegEnablePulse;
    cfg_data_i  <= pulse;
    @(posedge clk_i);
    cfg_index_i <= RegPowerUp;
    cfg_data_i  <= pwr;
    @(posedge clk_i);
    cfg_index_i <= RegCmdSettle;
    cfg_data_i  <= cmd;
    @(posedge clk_i);
    cfg_index_i <= RegClearSettle;
    cfg_data_i  <= clr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pulse_us    = pulse;
    powerup_us  = pwr;
    cmd_wait_us = cmd;
    clr_wait_us = clr;
  endtask

  // ---------------------------------------------------------------------
  // Result side. Each transfer is checked against the oldest owed segment,
  // then a stall is drawn before pop is raised again.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (owed_segs.size() == 0) begin
          report_mismatch($sformatf("segment %0d arrived with none owed", seg_count));
        end else begin
          if (reg_select_o !== owed_segs[0].rs)
            report_mismatch($sformatf("reg_select of segment %0d: expected %0h, got %0h",
                                      seg_count, owed_segs[0].rs, reg_select_o));
          if (enable_o !== owed_segs[0].en)
            report_mismatch($sformatf("enable of segment %0d: expected %0h, got %0h",
                                      seg_count, owed_segs[0].en, enable_o));
          if (nibble_o !== owed_segs[0].nib)
            report_mismatch($sformatf("nibble of segment %0d: expected %0h, got %0h",
                                      seg_count, owed_segs[0].nib, nibble_o));
          if (hold_us_o !== owed_segs[0].hold)
            report_mismatch($sformatf("hold_us of segment %0d: expected %0d, got %0d",
                                      seg_count, owed_segs[0].hold, hold_us_o));
          if (last_o !== owed_segs[0].last)
            report_mismatch($sformatf("last of segment %0d: expected %0h, got %0h",
                                      seg_count, owed_segs[0].last, last_o));
          void'(owed_segs.pop_front());
        end
        seg_count++;
        stall_left = snk_idle ? $urandom_range(0, 15) : 0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    lcd_req_t    r;
    logic [15:0] cfg_vals [4];
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under the reset timing values.
    foreach (directed_rows[i]) send_request(directed_rows[i]);
    drain_block();

    // Random phases: all-zero timing, all-ones timing, two random settings
    // and finally the reset values again. Most requests are well formed;
    // about a quarter of the gotos aim at a line that does not exist.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: cfg_vals = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        1: cfg_vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        4: cfg_vals = '{EnablePulseRst, PowerUpRst, CmdSettleRst, ClearSettleRst};
        default: begin
          foreach (cfg_vals[k]) cfg_vals[k] = 16'($urandom);
        end
      endcase
      set_timing(cfg_vals[0], cfg_vals[1], cfg_vals[2], cfg_vals[3]);
      for (int n = 0; n < PhaseItems; n++) begin
        // Every 25 requests each side picks again whether it idles at all,
        // so long stretches at full rate alternate with random gaps.
        if (n % 25 == 0) begin
          src_idle = ($urandom_range(0, 3) != 0);
          snk_idle = ($urandom_range(0, 3) != 0);
        end
        r.fn       = func_e'($urandom_range(0, 3));
        r.value    = 8'($urandom);
        r.line     = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(4, 7))
                                                 : 3'($urandom_range(0, 3));
        r.column   = 7'($urandom);
        r.typed    = 1'b0;
        r.silent   = 1'b0;
        r.rs       = 1'b0;
        r.bus_byte = 8'h00;
        send_request(r);
      end
      drain_block();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/clns_pkg.sv
rtl/clns_front.sv
rtl/clns_queue.sv
rtl/clns_back.sv
rtl/char_lcd_nibble_sequencer.sv
tb/tb_top.sv
